@@ design/tkst_pkg.sv @@
// Shared types and constants for the top-k score table.
package tkst_pkg;

    localparam int KEY_W             = 64;
    localparam int SCORE_W           = 24;
    localparam int RANK_W            = 3;
    localparam int TABLE_ENTRIES_DEF = 5;
    localparam logic [7:0] RESET_CHAR_BASE = 8'h41;
    localparam int RESET_STEP        = 50;

    typedef struct packed {
        logic [KEY_W-1:0]   player_key;
        logic [SCORE_W-1:0] offered_score;
    } offer_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank_position;
        logic [KEY_W-1:0]   entry_key;
        logic [SCORE_W-1:0] entry_score;
        logic               accepted;
        logic               last_entry;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } entry_t;

    // Passed from a cell to the cell below it during an update
    typedef struct packed {
        entry_t r;      // entry after removal of the replaced slot
        logic   g;      // removed-table entry scores below the candidate
        logic   past;   // at or below the removed slot
    } link_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_UPDATE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

@@ design/tkst_cell.sv @@
// One table position: holds an entry, compares it with an offer, shifts with neighbors.
module tkst_cell
    import tkst_pkg::*;
#(
    parameter logic [KEY_W-1:0]   RESET_KEY   = '0,
    parameter logic [SCORE_W-1:0] RESET_SCORE = '0,
    parameter bit                 IS_LAST     = 1'b0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  offer_t   probe,     // live offer, compared at accept
    input  offer_t   cand,      // latched offer, inserted on update
    input  entry_t   below,     // entry of the next lower position
    input  link_t    up_link,
    input  logic     sel,       // this slot is the one removed
    output entry_t   entry,
    output link_t    down_link,
    output logic     match,
    output logic     gt
);

    entry_t entry_reg, entry_next;
    logic   match_reg, match_next;
    logic   gt_reg, gt_next;
    entry_t r;
    logic   past;
    logic   g;

    always_comb
    begin
        past = up_link.past | sel;
        r    = past ? below : entry_reg;
        g    = IS_LAST || (r.score < cand.offered_score);
    end

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        gt_next    = gt_reg;
        unique case (op)
            CELL_HOLD:
            begin
            end
            CELL_MATCH:
            begin
                match_next = (probe.player_key == entry_reg.key);
                gt_next    = (probe.offered_score > entry_reg.score);
            end
            CELL_UPDATE:
            begin
                if (!g)
                begin
                    entry_next = r;
                end
                else if (!up_link.g)
                begin
                    entry_next.key   = cand.player_key;
                    entry_next.score = cand.offered_score;
                end
                else
                begin
                    entry_next = up_link.r;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = below;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.key   <= RESET_KEY;
            entry_reg.score <= RESET_SCORE;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        gt_reg    <= gt_next;
    end

    assign entry          = entry_reg;
    assign match          = match_reg;
    assign gt             = gt_reg;
    assign down_link.r    = r;
    assign down_link.g    = g;
    assign down_link.past = past;

endmodule

@@ design/top_k_score_table.sv @@
// Top level of the top-k score table: cell chain, offer register and sequencer.
//
// Keeps TABLE_ENTRIES key/score entries in descending score order. An offer is
// taken when start is high and busy is low. The cycle after acceptance updates
// the table in one step if the offer wins a place; then the whole table comes
// out, one entry per cycle from position 0 down, each marked by result_valid
// for exactly one cycle, the final one with last_entry set. The receiver cannot
// stall the stream. A new offer is taken only once the whole table is out:
// the accept cycle, the update cycle, then the table rotating through cell 0 to
// the output. busy stays high from the update cycle through the final entry.
module top_k_score_table
    import tkst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  offer_t  offer,
    output logic    busy,
    output logic    result_valid,
    output result_t result
);

    localparam int N  = TABLE_ENTRIES;
    localparam int CW = $clog2(N);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    offer_t offer_reg;
    logic   ge_last_reg;
    logic   accepted_reg, accepted_next;

    cell_op_t cell_op;
    entry_t   entries [N];
    link_t    links   [N+1];
    logic [N-1:0] match_vec;
    logic [N-1:0] gt_vec;
    logic [N-1:0] sel_vec;
    logic found;
    logic take;
    logic last_emit;
    logic [CW+2:0] rank_wide;

    assign links[0] = '0;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            localparam logic [7:0] RCHAR = 8'(RESET_CHAR_BASE + 8'(N - 1 - i));
            localparam logic [KEY_W-1:0] RKEY =
                {{(KEY_W-24){1'b0}}, RCHAR, RCHAR, RCHAR};
            localparam logic [SCORE_W-1:0] RSCORE = SCORE_W'(RESET_STEP * (N - i));

            tkst_cell #(
                .RESET_KEY   (RKEY),
                .RESET_SCORE (RSCORE),
                .IS_LAST     (i == N - 1)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .probe     (offer),
                .cand      (offer_reg),
                .below     (entries[(i + 1) % N]),
                .up_link   (links[i]),
                .sel       (sel_vec[i]),
                .entry     (entries[i]),
                .down_link (links[i+1]),
                .match     (match_vec[i]),
                .gt        (gt_vec[i])
            );

            // removed slot: the matching key, or the lowest entry for a new key
            assign sel_vec[i] = found ? match_vec[i] : (i == N - 1);
        end
    endgenerate

    assign found     = |match_vec;
    assign take      = found ? |(match_vec & gt_vec) : ge_last_reg;
    assign last_emit = (cnt_reg == CW'(N - 1));

    // next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        accepted_next = accepted_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                accepted_next = take;
                cnt_next      = '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (last_emit)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy         = 1'b1;
        result_valid = 1'b0;
        cell_op      = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy    = 1'b0;
                cell_op = start ? CELL_MATCH : CELL_HOLD;
            end
            ST_UPDATE:
            begin
                cell_op = take ? CELL_UPDATE : CELL_HOLD;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                cell_op      = CELL_ROTATE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            accepted_reg <= accepted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            offer_reg   <= offer;
            ge_last_reg <= (offer.offered_score >= entries[N-1].score);
        end
    end

    assign rank_wide = {3'b000, cnt_reg};

    always_comb
    begin
        result.rank_position = rank_wide[RANK_W-1:0];
        result.entry_key     = entries[0].key;
        result.entry_score   = entries[0].score;
        result.accepted      = accepted_reg;
        result.last_entry    = last_emit;
    end

    // keys in the table stay unique, so at most one cell matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $onehot0(match_vec))
        else $error("more than one table key matched the offer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("result emitted in the update cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_entry) |=> !busy)
        else $error("block still busy after the final entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_entry) |=> (result_valid &&
            result.accepted == $past(result.accepted)))
        else $error("entry stream broken or accepted flag changed");

endmodule

@@ verif/top_k_score_table_check.sv @@
// Checker for the top-k score table: predicts the table after each offer and compares the rows.
module top_k_score_table_check
    import tkst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  offer_t  offer,
    input  logic    busy,
    input  logic    result_valid,
    input  result_t result,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t  board [TABLE_ENTRIES];
    result_t table_rows [$];
    result_t due_row;

    function automatic void load_reset_board();
        logic [7:0] c;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            c = RESET_CHAR_BASE + 8'(TABLE_ENTRIES - 1 - i);
            board[i].key   = {40'b0, c, c, c};
            board[i].score = SCORE_W'(RESET_STEP * (TABLE_ENTRIES - i));
        end
    endfunction

    // Drop the entry at pos, then seat e below every entry scoring >= e.score
    function automatic void seat_entry(int pos, entry_t e);
        int q;
        q = TABLE_ENTRIES - 1;
        for (int i = pos; i < TABLE_ENTRIES - 1; i++)
            board[i] = board[i + 1];
        for (int i = 0; i < TABLE_ENTRIES - 1; i++)
            if (q == TABLE_ENTRIES - 1 && board[i].score < e.score)
                q = i;
        for (int i = TABLE_ENTRIES - 1; i > q; i--)
            board[i] = board[i - 1];
        board[q] = e;
    endfunction

    function automatic void apply_offer(offer_t o);
        int      hit;
        logic    took;
        entry_t  e;
        result_t row;
        hit  = -1;
        took = 1'b0;
        e.key   = o.player_key;
        e.score = o.offered_score;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && board[i].key == o.player_key)
                hit = i;
        if (hit >= 0)
        begin
            if (o.offered_score > board[hit].score)
            begin
                took = 1'b1;
                seat_entry(hit, e);
            end
        end
        else if (board[TABLE_ENTRIES - 1].score <= o.offered_score)
        begin
            took = 1'b1;
            seat_entry(TABLE_ENTRIES - 1, e);
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            row.rank_position = RANK_W'(i);
            row.entry_key     = board[i].key;
            row.entry_score   = board[i].score;
            row.accepted      = took;
            row.last_entry    = (i == TABLE_ENTRIES - 1);
            table_rows.push_back(row);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reset_board();
            table_rows.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (table_rows.size() == 0)
                begin
                    $error("result with no transaction outstanding: key %0h score %0h",
                           result.entry_key, result.entry_score);
                    fail_count++;
                end
                else
                begin
                    due_row = table_rows.pop_front();
                    check_field("rank_position", 64'(due_row.rank_position),
                                64'(result.rank_position));
                    check_field("entry_key", due_row.entry_key, result.entry_key);
                    check_field("entry_score", 64'(due_row.entry_score),
                                64'(result.entry_score));
                    check_field("accepted", 64'(due_row.accepted), 64'(result.accepted));
                    check_field("last_entry", 64'(due_row.last_entry),
                                64'(result.last_entry));
                end
            end
            if (start && !busy)
                apply_offer(offer);
            pending = table_rows.size();
        end
    end

endmodule

@@ verif/top_k_score_table_test.sv @@
// Testbench top for the top-k score table: clock, reset, offer stimulus and verdict.
module top_k_score_table_test
    import tkst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 456;
    localparam int QUIET_TAIL = 60;

    localparam logic [63:0] KEY_EEE = 64'h454545;
    localparam logic [63:0] KEY_CCC = 64'h434343;
    localparam logic [63:0] KEY_BBB = 64'h424242;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    offer_t  offer = '0;
    logic    busy;
    logic    result_valid;
    result_t result;
    int      fail_count;
    int      pending;

    logic [63:0] key_pool [8];
    logic [23:0] recent_scores [8];

    top_k_score_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .offer        (offer),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    top_k_score_table_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .offer        (offer),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic offer_t mk_offer(logic [63:0] k, logic [23:0] s);
        offer_t o;
        o.player_key    = k;
        o.offered_score = s;
        return o;
    endfunction

    // Full 64-bit noise or a zero-padded printable name of 1..8 chars
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int          len;
        k = '0;
        if ($urandom_range(0, 1) == 0)
            k = {$urandom, $urandom};
        else
        begin
            len = $urandom_range(1, 8);
            for (int b = 0; b < len; b++)
                k[8*b +: 8] = 8'($urandom_range(8'h20, 8'h7E));
        end
        return k;
    endfunction

    // Called at a falling edge; returns at the falling edge after the offer is taken
    task automatic send_offer(input offer_t o);
        while (busy)
            @(negedge clk);
        start = 1'b1;
        offer = o;
        @(negedge clk);
        start = 1'b0;
    endtask

    initial
    begin
        logic [63:0] k;
        logic [23:0] s;
        longint      level;
        int          pick;
        logic [7:0]  c;

        for (int i = 0; i < 8; i++)
        begin
            key_pool[i]      = fresh_key();
            recent_scores[i] = '0;
        end

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: present-key ties and drops, lowest-entry ties, top ties, wide values
        send_offer(mk_offer(KEY_EEE, 24'd250));
        send_offer(mk_offer(KEY_CCC, 24'd100));
        send_offer(mk_offer(64'h44455A, 24'd49));
        send_offer(mk_offer(64'h0, 24'd50));
        send_offer(mk_offer(KEY_BBB, 24'd150));
        send_offer(mk_offer(64'h0, 24'd200));
        send_offer(mk_offer('1, 24'hFFFFFF));
        send_offer(mk_offer(64'h4843_4F45_4349_4C41, 24'hFFFFFF));
        send_offer(mk_offer('1, 24'd0));
        send_offer(mk_offer(KEY_EEE, 24'd251));
        send_offer(mk_offer(64'h8000_0000_0000_0001, 24'h800000));
        send_offer(mk_offer(64'h5555_5555_5555_5555, 24'hAAAAAA));
        send_offer(mk_offer(64'hAAAA_AAAA_AAAA_AAAA, 24'h555555));
        send_offer(mk_offer(64'h1234, 24'd0));

        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // scores ride a rising level so the table keeps turning over
            level = 64'h600000 + (longint'(n) * 64'hA00000) / N_RANDOM;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                level = level + $urandom_range(0, 40000);
            else if (pick < 65)
                level = recent_scores[$urandom_range(0, 7)];
            else if (pick < 80)
                level = $urandom_range(0, 32'(level));
            else if (pick < 97)
                level = $urandom_range(0, 24'hFFFFFF);
            else
                level = 24'hFFFFFF;
            if (level > 64'hFFFFFF)
                level = 64'hFFFFFF;
            s = 24'(level);
            recent_scores[$urandom_range(0, 7)] = s;

            pick = $urandom_range(0, 99);
            if (pick < 65)
                k = key_pool[$urandom_range(0, 7)];
            else if (pick < 75)
            begin
                c = RESET_CHAR_BASE + 8'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
                k = {40'b0, c, c, c};
            end
            else
            begin
                k = fresh_key();
                key_pool[$urandom_range(0, 7)] = k;
            end

            if (n == N_RANDOM / 2)
                while (pending != 0)
                    @(negedge clk);
            if (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 11)) @(negedge clk);

            send_offer(mk_offer(k, s));
        end

        while (pending != 0)
            @(negedge clk);
        repeat (TABLE_ENTRIES_DEF + 4) @(negedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/tkst_pkg.sv
design/tkst_cell.sv
design/top_k_score_table.sv
verif/top_k_score_table_check.sv
verif/top_k_score_table_test.sv
